FILE: hdl/swsf_pkg.sv
// ----------------------------------------------------------------------------
// swsf_pkg
// Shared types and constants of the sliding-window sender with fast
// retransmit.
// ----------------------------------------------------------------------------
`default_nettype none

package swsf_pkg;

    localparam int unsigned SEQ_W          = 32;
    localparam int unsigned WIN_REG_W      = 4;
    localparam int unsigned DUP_W          = 3;
    localparam int unsigned WINDOW_MAX_DEF = 8;

    localparam logic [SEQ_W-1:0]     SEQ_RESET     = 32'd1;
    localparam logic [WIN_REG_W-1:0] WINDOW_RESET  = 4'd4;
    localparam logic [DUP_W-1:0]     DUP_THRESHOLD = 3'd4;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        TIMER_NONE    = 2'd0,
        TIMER_STOP    = 2'd1,
        TIMER_START   = 2'd2,
        TIMER_RESTART = 2'd3
    } t_timer_act;

    typedef struct packed {
        t_opcode          opcode;
        logic [SEQ_W-1:0] ack_number;
        logic             ack_checksum_ok;
    } t_item;

    typedef struct packed {
        logic             accepted;
        logic             transmit_valid;
        logic [SEQ_W-1:0] transmit_seq;
        t_timer_act       timer_action;
        logic [SEQ_W-1:0] timer_seq;
        logic             window_full;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/swsf_if.sv
// ----------------------------------------------------------------------------
// swsf_if
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface swsf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] ack_number;
    logic        ack_checksum_ok;

    modport source (output valid, output opcode, output ack_number,
                    output ack_checksum_ok, input ready);
    modport sink   (input valid, input opcode, input ack_number,
                    input ack_checksum_ok, output ready);
endinterface

interface swsf_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        transmit_valid;
    logic [31:0] transmit_seq;
    logic [1:0]  timer_action;
    logic [31:0] timer_seq;
    logic        window_full;

    modport source (output valid, output accepted, output transmit_valid,
                    output transmit_seq, output timer_action, output timer_seq,
                    output window_full, input ready);
    modport sink   (input valid, input accepted, input transmit_valid,
                    input transmit_seq, input timer_action, input timer_seq,
                    input window_full, output ready);
endinterface

`default_nettype wire

FILE: hdl/swsf_core.sv
// ----------------------------------------------------------------------------
// swsf_core
// Window pointers, in-flight count and duplicate-ack counter, with the
// combinational decision logic for send, ack and timeout transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module swsf_core
    import swsf_pkg::*;
#(
    parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire t_item                i_item,
    input  wire logic [WIN_REG_W-1:0] i_window_size,
    output t_result                   o_result
);

    localparam int unsigned FW = $clog2(WINDOW_MAX + 1);
    localparam int unsigned CW = (FW > WIN_REG_W) ? FW : WIN_REG_W;

    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_next, n_next;
    logic [FW-1:0]    r_flight, n_flight;
    logic [DUP_W-1:0] r_dup, n_dup;

    logic [CW-1:0]    win_ext;
    logic [CW-1:0]    eff_win;
    logic [SEQ_W-1:0] ack_dist;
    logic             dist_in_window;
    logic [DUP_W-1:0] dup_inc;

    assign win_ext = CW'(i_window_size);
    assign eff_win = (win_ext > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : win_ext;

    // modular distance of the ack above base, in-flight count is always small
    assign ack_dist       = i_item.ack_number - r_base;
    assign dist_in_window = ((ack_dist >> FW) == '0) && (ack_dist[FW-1:0] <= r_flight);
    assign dup_inc        = r_dup + 1'b1;

    always_comb begin
        n_base   = r_base;
        n_next   = r_next;
        n_flight = r_flight;
        n_dup    = r_dup;
        o_result = '0;

        case (i_item.opcode)
            OP_SEND: begin
                if (CW'(r_flight) < eff_win) begin
                    o_result.accepted       = 1'b1;
                    o_result.transmit_valid = 1'b1;
                    o_result.transmit_seq   = r_next;
                    if (r_flight == '0) begin
                        o_result.timer_action = TIMER_START;
                        o_result.timer_seq    = r_next;
                    end
                    n_next   = r_next + 1'b1;
                    n_flight = r_flight + 1'b1;
                end
            end
            OP_ACK: begin
                if (i_item.ack_checksum_ok && (r_flight != '0)) begin
                    if (ack_dist == '0) begin
                        n_dup = dup_inc;
                        if (dup_inc >= DUP_THRESHOLD) begin
                            o_result.transmit_valid = 1'b1;
                            o_result.transmit_seq   = r_base;
                            o_result.timer_action   = TIMER_RESTART;
                            o_result.timer_seq      = r_base;
                            n_dup                   = '0;
                        end
                    end else if (dist_in_window) begin
                        n_base   = i_item.ack_number;
                        n_dup    = DUP_W'(1);
                        n_flight = r_flight - ack_dist[FW-1:0];
                        if (n_flight == '0) begin
                            o_result.timer_action = TIMER_STOP;
                            o_result.timer_seq    = r_base;
                        end else begin
                            o_result.timer_action = TIMER_RESTART;
                            o_result.timer_seq    = i_item.ack_number;
                        end
                    end
                end
            end
            OP_TIMEOUT: begin
                if (r_flight != '0) begin
                    o_result.transmit_valid = 1'b1;
                    o_result.transmit_seq   = r_base;
                    o_result.timer_action   = TIMER_RESTART;
                    o_result.timer_seq      = r_base;
                end
            end
            default: begin
            end
        endcase

        o_result.window_full = (CW'(n_flight) >= eff_win);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= SEQ_RESET;
            r_next   <= SEQ_RESET;
            r_flight <= '0;
            r_dup    <= '0;
        end else if (i_fire) begin
            r_base   <= n_base;
            r_next   <= n_next;
            r_flight <= n_flight;
            r_dup    <= n_dup;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sliding_window_sender_fast_retransmit.sv
// result: registered, valid in the cycle after its request transaction is taken
// throughput: one request per cycle, the output register frees in the same
// cycle it is read, so ready only drops while a result waits unread
// reset: synchronous active low, pointers go to 1, counters to 0, window to 4
// no clearing pass after reset, the block takes requests in the next cycle
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit
// Top level: APB window register, request handshake, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_fast_retransmit
    import swsf_pkg::*;
#(
    parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    swsf_req_if.sink         i_req,
    swsf_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] ADDR_WINDOW_SIZE = 2'd0;

    logic [WIN_REG_W-1:0] r_window_size;
    logic                 r_out_valid;
    t_result              r_result;

    t_item   item;
    t_result result;
    logic    fire;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_SIZE) ? 32'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE)) begin
            r_window_size <= pwdata[WIN_REG_W-1:0];
        end
    end

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign fire        = i_req.valid && i_req.ready;

    assign item.opcode          = t_opcode'(i_req.opcode);
    assign item.ack_number      = i_req.ack_number;
    assign item.ack_checksum_ok = i_req.ack_checksum_ok;

    swsf_core #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (item),
        .i_window_size (r_window_size),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_result.accepted;
    assign o_rsp.transmit_valid = r_result.transmit_valid;
    assign o_rsp.transmit_seq   = r_result.transmit_seq;
    assign o_rsp.timer_action   = r_result.timer_action;
    assign o_rsp.timer_seq      = r_result.timer_seq;
    assign o_rsp.window_full    = r_result.window_full;

endmodule

`default_nettype wire

FILE: hdl/swsf_checker.sv
// ----------------------------------------------------------------------------
// swsf_checker
// Port-level checks of the sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swsf_checker
    import swsf_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_accepted,
    input wire logic        i_transmit_valid,
    input wire logic [31:0] i_transmit_seq,
    input wire logic [1:0]  i_timer_action,
    input wire logic [31:0] i_timer_seq
);

    // a taken request always shows a result in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("result missing after request transaction");

    // stalled result holds its sequence numbers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_transmit_seq) && $stable(i_timer_seq)))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_accepted) |-> i_transmit_valid)
        else $error("accepted send without transmit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_transmit_valid) |-> (i_transmit_seq == '0))
        else $error("transmit sequence set without transmit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_timer_action == TIMER_NONE)) |-> (i_timer_seq == '0))
        else $error("timer sequence set without timer command");

endmodule

bind sliding_window_sender_fast_retransmit swsf_checker u_swsf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_accepted       (o_rsp.accepted),
    .i_transmit_valid (o_rsp.transmit_valid),
    .i_transmit_seq   (o_rsp.transmit_seq),
    .i_timer_action   (o_rsp.timer_action),
    .i_timer_seq      (o_rsp.timer_seq)
);

`default_nettype wire
